### rtl/core/bce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_pkg
// Widths, types and helpers for the Bezier curve evaluator pipeline.
// ----------------------------------------------------------------------------
package bce_pkg;

	localparam int NUM_POINTS = 4;

	localparam int PT_W  = 32;               // control point, Q16.16
	localparam int T_W   = 17;               // t and 1-t, Q0.16 with 1.0
	localparam int T3_W  = T_W + 1;          // 3*t
	localparam int DEG_W = 2;
	localparam int SQ_W  = 34;               // second order terms
	localparam int CU_W  = SQ_W + T_W;       // raw third order products
	localparam int W_W   = 49;               // Bernstein weight, at most 2^48
	localparam int WL_W  = 25;               // low slice of a weight
	localparam int WH_W  = W_W - WL_W;       // high slice of a weight
	localparam int LO_W  = PT_W + WL_W + 1;  // point times low slice
	localparam int HI_W  = PT_W + WH_W + 1;  // point times high slice
	localparam int ACC_W = 82;               // exact weighted sum
	localparam int SUM_W = W_W + 2;          // sum of four weights

	localparam logic [T_W-1:0]   T_ONE      = T_W'(65536);
	localparam logic [DEG_W-1:0] DEG_RESET  = 2'd3;
	localparam logic [DEG_W-1:0] DEG_MAX    =
		(NUM_POINTS - 1 > 3) ? 2'd3 : DEG_W'(NUM_POINTS - 1);

	localparam logic signed [ACC_W-1:0] VAL_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] VAL_MIN = -ACC_W'(64'sd2147483648);

	typedef logic signed [PT_W-1:0]  point_t;
	typedef logic [W_W-1:0]          weight_t;
	typedef logic signed [LO_W-1:0]  prod_lo_t;
	typedef logic signed [HI_W-1:0]  prod_hi_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [DEG_W-1:0]        deg_t;

	// one half of 2^(16n), zero for degree zero
	function automatic acc_t round_half(input deg_t n);
		acc_t h;
		unique case (n)
			2'd0: h = '0;
			2'd1: h = acc_t'(1) <<< 15;
			2'd2: h = acc_t'(1) <<< 31;
			2'd3: h = acc_t'(1) <<< 47;
			default: h = '0;
		endcase
		return h;
	endfunction

	// total weight 2^(16n)
	function automatic logic [SUM_W-1:0] weight_total(input deg_t n);
		logic [SUM_W-1:0] s;
		s = SUM_W'(1) << {n, 4'b0000};
		return s;
	endfunction

endpackage

### rtl/core/bezier_curve_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_evaluator_core
// Cubic (or lower degree) Bezier evaluation in Bernstein form, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   An item (point_0..point_3, curve_param) transfers on a clock edge with
//   start high and busy low. busy is never raised, so one item per cycle.
//   curve_value is shown for one cycle with done high as the item leaves
//   the pipeline; results leave in the order the items came in.
//   Throughput is one item per clock; the 8-stage multiply/add pipeline
//   (clamp, squares, cubes, split point-by-weight products, three adder
//   levels, round and saturate) sets the latency.
//   curve_degree must be written with cfg_we/cfg_wdata only while no item
//   is in flight; the core does not enforce this. It is sampled per item
//   on entry. Degree 0 returns point_0. curve_param above 1.0 is treated
//   as 1.0. Rounding is to nearest with ties toward plus infinity.
//   Reset clears the pipeline valid bits and sets the degree to 3. The
//   receiver cannot stall: results must be taken when done is high.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator_core
	import bce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cfg_we,
	input  logic [DEG_W-1:0]       cfg_wdata,
	input  logic signed [PT_W-1:0] point_0,
	input  logic signed [PT_W-1:0] point_1,
	input  logic signed [PT_W-1:0] point_2,
	input  logic signed [PT_W-1:0] point_3,
	input  logic [T_W-1:0]         curve_param,
	output logic                   done,
	output logic signed [PT_W-1:0] curve_value
);

	logic   degree_q_unused;
	deg_t   degree_q;

	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	logic   valid_s5, valid_s6, valid_s7, valid_s8;

	deg_t   deg_s1, deg_s2, deg_s3, deg_s4, deg_s5, deg_s6, deg_s7;

	logic [T_W-1:0]  t_s1, u_s1, t_s2, u_s2;
	logic [T3_W-1:0] t3_s1;
	logic [SQ_W-1:0] t2_s2, u2_s2, tu_s2, tu3_s2;

	point_t   pts_s1 [4];
	point_t   pts_s2 [4];
	point_t   pts_s3 [4];
	weight_t  w_s3   [4];
	prod_lo_t lo_s4  [4];
	prod_hi_t hi_s4  [4];
	acc_t     prod_s5[4];
	acc_t     s01_s6, s23_s6, total_s7;
	point_t   value_s8;

	logic           accept;
	logic [T_W-1:0] t_clamp;
	deg_t           deg_eff;
	logic [CU_W-1:0] cube [4];
	weight_t        w_nxt[4];
	acc_t           rnd, shf;
	point_t         value_nxt;
	logic [SUM_W-1:0] wsum_s3;

	assign degree_q_unused = 1'b0;
	assign busy   = degree_q_unused;
	assign accept = start & ~busy;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEG_RESET;
		end else if (cfg_we) begin
			degree_q <= cfg_wdata;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// stage 1: clamp t, form 1-t and 3t
	always_comb begin
		t_clamp = (curve_param > T_ONE) ? T_ONE : curve_param;
		deg_eff = (degree_q > DEG_MAX) ? DEG_MAX : degree_q;
	end

	always_ff @(posedge clk) begin
		t_s1      <= t_clamp;
		u_s1      <= T_ONE - t_clamp;
		t3_s1     <= {t_clamp, 1'b0} + T3_W'(t_clamp);
		deg_s1    <= deg_eff;
		pts_s1[0] <= point_0;
		pts_s1[1] <= point_1;
		pts_s1[2] <= point_2;
		pts_s1[3] <= point_3;
	end

	// stage 2: second order terms
	always_ff @(posedge clk) begin
		t2_s2  <= SQ_W'(t_s1) * SQ_W'(t_s1);
		u2_s2  <= SQ_W'(u_s1) * SQ_W'(u_s1);
		tu_s2  <= SQ_W'(t_s1) * SQ_W'(u_s1);
		tu3_s2 <= SQ_W'(u_s1) * SQ_W'(t3_s1);
		t_s2   <= t_s1;
		u_s2   <= u_s1;
		deg_s2 <= deg_s1;
		pts_s2 <= pts_s1;
	end

	// stage 3: third order terms and weight select
	always_comb begin
		cube[0] = CU_W'(u2_s2)  * CU_W'(u_s2);
		cube[1] = CU_W'(tu3_s2) * CU_W'(u_s2);
		cube[2] = CU_W'(tu3_s2) * CU_W'(t_s2);
		cube[3] = CU_W'(t2_s2)  * CU_W'(t_s2);
		unique case (deg_s2)
			2'd0: begin
				w_nxt[0] = W_W'(1);
				w_nxt[1] = '0;
				w_nxt[2] = '0;
				w_nxt[3] = '0;
			end
			2'd1: begin
				w_nxt[0] = W_W'(u_s2);
				w_nxt[1] = W_W'(t_s2);
				w_nxt[2] = '0;
				w_nxt[3] = '0;
			end
			2'd2: begin
				w_nxt[0] = W_W'(u2_s2);
				w_nxt[1] = W_W'({tu_s2, 1'b0});
				w_nxt[2] = W_W'(t2_s2);
				w_nxt[3] = '0;
			end
			default: begin
				w_nxt[0] = cube[0][W_W-1:0];
				w_nxt[1] = cube[1][W_W-1:0];
				w_nxt[2] = cube[2][W_W-1:0];
				w_nxt[3] = cube[3][W_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		w_s3   <= w_nxt;
		deg_s3 <= deg_s2;
		pts_s3 <= pts_s2;
	end

	// stage 4: point times weight, split in two slices
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			lo_s4[i] <= LO_W'(pts_s3[i] * $signed({1'b0, w_s3[i][WL_W-1:0]}));
			hi_s4[i] <= HI_W'(pts_s3[i] * $signed({1'b0, w_s3[i][W_W-1:WL_W]}));
		end
		deg_s4 <= deg_s3;
	end

	// stage 5: recombine slices
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_s5[i] <= ACC_W'(lo_s4[i]) + (ACC_W'(hi_s4[i]) <<< WL_W);
		end
		deg_s5 <= deg_s4;
	end

	// stage 6 and 7: adder tree
	always_ff @(posedge clk) begin
		s01_s6   <= prod_s5[0] + prod_s5[1];
		s23_s6   <= prod_s5[2] + prod_s5[3];
		deg_s6   <= deg_s5;
		total_s7 <= s01_s6 + s23_s6;
		deg_s7   <= deg_s6;
	end

	// stage 8: round, scale back, saturate
	always_comb begin
		rnd = total_s7 + round_half(deg_s7);
		shf = rnd >>> {deg_s7, 4'b0000};
		if (shf > VAL_MAX) begin
			value_nxt = PT_W'(VAL_MAX);
		end else if (shf < VAL_MIN) begin
			value_nxt = PT_W'(VAL_MIN);
		end else begin
			value_nxt = PT_W'(shf);
		end
	end

	always_ff @(posedge clk) begin
		value_s8 <= value_nxt;
	end

	assign done        = valid_s8;
	assign curve_value = value_s8;

	assign wsum_s3 = SUM_W'(w_s3[0]) + SUM_W'(w_s3[1]) + SUM_W'(w_s3[2]) + SUM_W'(w_s3[3]);

	// every transfer yields exactly one result at the pipeline output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##7 valid_s8)
		else $error("result strobe missing after pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s8 |-> $past(valid_s1, 7))
		else $error("result strobe without a transfer");

	// Bernstein weights form a partition of unity
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (wsum_s3 == weight_total(deg_s3)))
		else $error("weights do not sum to one");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Bezier curve evaluator core. A clocked driver
// sends queued curve items (four Q16.16 points and a Q1.16 parameter), and a
// clocked monitor checks each strobed curve value against an exact
// Bernstein-sum prediction, rounded half up and saturated. The run walks
// through every curve degree under several sender idle rates.
// ----------------------------------------------------------------------------
module testbench
	import bce_pkg::*;
();

	typedef struct {
		point_t          pt [4];
		logic [T_W-1:0]  t;
	} curve_item_t;

	localparam int unsigned PASCAL [4][4] = '{
		'{1, 0, 0, 0},
		'{1, 1, 0, 0},
		'{1, 2, 1, 0},
		'{1, 3, 3, 1}
	};
	localparam int          ITEMS_PER_PHASE = 120;
	localparam int          TAIL_CYCLES     = 12;
	localparam deg_t        DEG_SEQ [4]     = '{2'd1, 2'd0, 2'd2, 2'd3};
	localparam int          IDLE_SEQ [3]    = '{0, 70, 8};

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   start       = 1'b0;
	logic                   busy;
	logic                   cfg_we      = 1'b0;
	logic [DEG_W-1:0]       cfg_wdata   = '0;
	logic signed [PT_W-1:0] point_0     = '0;
	logic signed [PT_W-1:0] point_1     = '0;
	logic signed [PT_W-1:0] point_2     = '0;
	logic signed [PT_W-1:0] point_3     = '0;
	logic [T_W-1:0]         curve_param = '0;
	logic                   done;
	logic signed [PT_W-1:0] curve_value;

	curve_item_t items_to_send [$];
	point_t      expected_values [$];
	deg_t        degree_model = DEG_RESET;
	int          idle_pct     = 0;
	int          error_count  = 0;

	bezier_curve_evaluator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.point_0     (point_0),
		.point_1     (point_1),
		.point_2     (point_2),
		.point_3     (point_3),
		.curve_param (curve_param),
		.done        (done),
		.curve_value (curve_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// exact weighted sum over 2^(16n), rounded half up, saturated
	function automatic point_t bezier_value(input deg_t deg_reg, input curve_item_t it);
		int                 n;
		int                 k;
		logic [T_W-1:0]     tc;
		logic [T_W-1:0]     uc;
		logic [63:0]        w;
		logic signed [95:0] acc;
		logic signed [95:0] half;
		n = int'(deg_reg);
		if (n > NUM_POINTS - 1)
			n = NUM_POINTS - 1;
		tc = (it.t > T_ONE) ? T_ONE : it.t;
		uc = T_ONE - tc;
		if (n == 0)
			return it.pt[0];
		acc = '0;
		for (int i = 0; i <= n; i++) begin
			w = 64'(PASCAL[n][i]);
			for (k = 0; k < n - i; k++)
				w = w * 64'(uc);
			for (k = 0; k < i; k++)
				w = w * 64'(tc);
			acc = acc + $signed({32'b0, w}) * 96'(it.pt[i]);
		end
		half = 96'sd1 <<< (16 * n - 1);
		acc  = (acc + half) >>> (16 * n);
		if (acc > 96'sd2147483647)
			return 32'sh7fffffff;
		if (acc < -96'sd2147483648)
			return 32'sh80000000;
		return point_t'(acc);
	endfunction

	function automatic curve_item_t make_item(input point_t p0, input point_t p1,
			input point_t p2, input point_t p3, input logic [T_W-1:0] t);
		curve_item_t it;
		it.pt[0] = p0;
		it.pt[1] = p1;
		it.pt[2] = p2;
		it.pt[3] = p3;
		it.t     = t;
		return it;
	endfunction

	function automatic point_t rand_point();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return point_t'(int'($urandom_range(0, 1023)) - 512);
			3: return point_t'(int'($urandom_range(0, 131071)) - 65536);
			default: return point_t'($urandom);
		endcase
	endfunction

	function automatic logic [T_W-1:0] rand_param();
		case ($urandom_range(0, 9))
			0: return T_ONE;
			1: return '0;
			2: return T_W'($urandom_range(65537, 131071));
			3: return $urandom_range(0, 1) ? T_W'(1) : T_W'(65535);
			default: return T_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic queue_item(input curve_item_t it);
		items_to_send.insert(items_to_send.size(), it);
	endtask

	task automatic push_directed();
		queue_item(make_item(32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, '0));
		queue_item(make_item(32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, T_ONE));
		queue_item(make_item(32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, T_W'(32768)));
		// exact half-LSB ties, positive and negative, for degrees 1..3
		queue_item(make_item(32'sd1, 32'sd0, 32'sd1, 32'sd0, T_W'(32768)));
		queue_item(make_item(-32'sd1, 32'sd0, -32'sd1, 32'sd0, T_W'(32768)));
		// parameter above one, then just below one
		queue_item(make_item(rand_point(), rand_point(), rand_point(),
			rand_point(), T_W'(131071)));
		queue_item(make_item(rand_point(), rand_point(), rand_point(),
			rand_point(), T_W'(65535)));
	endtask

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++)
			queue_item(make_item(rand_point(), rand_point(), rand_point(),
				rand_point(), rand_param()));
	endtask

	task automatic drain();
		while (items_to_send.size() != 0 || expected_values.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_degree(input deg_t d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we       <= 1'b0;
		degree_model = d;
	endtask

	// driver: one item per transfer; noise on the payload while start is low
	always @(posedge clk) begin : drive
		curve_item_t nxt;
		if (arst_n && start && !busy) begin
			expected_values.insert(expected_values.size(), bezier_value(degree_model,
				make_item(point_0, point_1, point_2, point_3, curve_param)));
			void'(items_to_send.pop_front());
		end
		if (arst_n && items_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
			nxt = items_to_send[0];
			start       <= 1'b1;
			point_0     <= nxt.pt[0];
			point_1     <= nxt.pt[1];
			point_2     <= nxt.pt[2];
			point_3     <= nxt.pt[3];
			curve_param <= nxt.t;
		end else begin
			start       <= 1'b0;
			point_0     <= point_t'($urandom);
			point_1     <= point_t'($urandom);
			point_2     <= point_t'($urandom);
			point_3     <= point_t'($urandom);
			curve_param <= T_W'($urandom);
		end
	end

	always @(posedge clk) begin : monitor
		point_t want;
		if (arst_n && done) begin
			if (expected_values.size() == 0) begin
				flag_mismatch($sformatf("curve_value %h with nothing pending", curve_value));
			end else begin
				want = expected_values.pop_front();
				if (curve_value !== want)
					flag_mismatch($sformatf("curve_value got %h want %h", curve_value, want));
			end
		end
	end

	initial begin
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset degree first
		idle_pct = 0;
		push_random(20);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			write_degree(DEG_SEQ[ph % 4]);
			idle_pct = IDLE_SEQ[ph % 3];
			if (ph < 4)
				push_directed();
			push_random(ITEMS_PER_PHASE);
			drain();
		end

		while (items_to_send.size() != 0)
			@(posedge clk);
		for (k = 0; k < 200 && expected_values.size() != 0; k++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_values.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_values.size()));

		if (error_count == 0) begin
			$display("[bezier_curve_evaluator_core] OK");
		end else begin
			$display("[bezier_curve_evaluator_core] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[bezier_curve_evaluator_core] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/bce_pkg.sv
rtl/core/bezier_curve_evaluator_core.sv
tb/testbench.sv
